### rtl/plm_pkg.sv
// Package for the positional list engine: action and status codes, the control word
// layout, flag group and the microcode table.
// Depends on nothing; used by positional_list_engine_core and plm_sequencer in rtl/.
package plm_pkg;

   localparam int CAPACITY_DEFAULT = 32;
   localparam int ACTION_W = 2;
   localparam int POS_W    = 6;
   localparam int CHAR_W   = 8;
   localparam int STATUS_W = 2;
   localparam int UPC_W    = 5;

   typedef logic [ACTION_W-1:0] action_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [UPC_W-1:0]    upc_type;

   localparam action_type ACT_ADD    = 2'd0;
   localparam action_type ACT_DELETE = 2'd1;
   localparam action_type ACT_GET    = 2'd2;
   localparam action_type ACT_PRINT  = 2'd3;

   localparam status_type ST_ELEMENT = 2'd0;
   localparam status_type ST_BAD_POS = 2'd1;
   localparam status_type ST_FULL    = 2'd2;
   localparam status_type ST_EMPTY   = 2'd3;

   typedef enum logic [2:0] {
      C_NEVER, C_ALWAYS, C_BAD_POS, C_FULL, C_EMPTY,
      C_IDX_AT_POS, C_IDX_AT_LEN, C_IDX_BELOW_LEN
   } cond_type;

   typedef enum logic [2:0] {
      IDX_HOLD, IDX_LOAD_LEN, IDX_LOAD_POS, IDX_ZERO, IDX_INC, IDX_DEC
   } idx_op_type;

   typedef enum logic [1:0] {
      RD_NONE, RD_IDX, RD_IDX_M1, RD_POS_M1
   } rd_sel_type;

   typedef enum logic [1:0] {
      WR_NONE, WR_RDATA_IDX, WR_RDATA_IDX_M1, WR_BYTE_IDX
   } wr_sel_type;

   typedef enum logic [1:0] {
      LEN_HOLD, LEN_INC, LEN_DEC
   } len_op_type;

   typedef enum logic [1:0] {
      EMIT_NONE, EMIT_ELEM_ONE, EMIT_ELEM_RUN, EMIT_ERR
   } emit_type;

   typedef struct packed {
      cond_type   cond;
      upc_type    target;
      idx_op_type idx_op;
      rd_sel_type rd_sel;
      wr_sel_type wr_sel;
      len_op_type len_op;
      emit_type   emit;
      status_type status;
      logic       done;
   } uword_type;

   typedef struct packed {
      logic bad_pos;
      logic full;
      logic empty;
      logic idx_at_pos;
      logic idx_at_len;
      logic idx_below_len;
   } flags_type;

   localparam upc_type U_ADD0 = 5'd0;
   localparam upc_type U_ADD1 = 5'd1;
   localparam upc_type U_ADD2 = 5'd2;
   localparam upc_type U_ADD3 = 5'd3;
   localparam upc_type U_ADD4 = 5'd4;
   localparam upc_type U_DEL0 = 5'd5;
   localparam upc_type U_DEL1 = 5'd6;
   localparam upc_type U_DEL2 = 5'd7;
   localparam upc_type U_DEL3 = 5'd8;
   localparam upc_type U_GET0 = 5'd9;
   localparam upc_type U_GET1 = 5'd10;
   localparam upc_type U_PRT0 = 5'd11;
   localparam upc_type U_PRT1 = 5'd12;
   localparam upc_type U_PRT2 = 5'd13;
   localparam upc_type U_ERRP = 5'd14;
   localparam upc_type U_ERRF = 5'd15;
   localparam upc_type U_ERRE = 5'd16;

   function automatic uword_type uw(
      input cond_type   cond,
      input upc_type    target,
      input idx_op_type idx_op,
      input rd_sel_type rd_sel,
      input wr_sel_type wr_sel,
      input len_op_type len_op,
      input emit_type   emit,
      input status_type status,
      input logic       done
   );
      uword_type w;
      w.cond   = cond;
      w.target = target;
      w.idx_op = idx_op;
      w.rd_sel = rd_sel;
      w.wr_sel = wr_sel;
      w.len_op = len_op;
      w.emit   = emit;
      w.status = status;
      w.done   = done;
      return w;
   endfunction

   function automatic uword_type uword_nop();
      return uw(C_NEVER, U_ADD0, IDX_HOLD, RD_NONE, WR_NONE, LEN_HOLD, EMIT_NONE,
                ST_ELEMENT, 1'b1);
   endfunction

   // cond true -> target; else done -> idle; else next step
   function automatic uword_type ucode_rom(input upc_type a);
      uword_type w;
      w = uword_nop();
      unique case (a)
         U_ADD0: w = uw(C_BAD_POS, U_ERRP, IDX_HOLD, RD_NONE, WR_NONE, LEN_HOLD,
                        EMIT_NONE, ST_ELEMENT, 1'b0);
         U_ADD1: w = uw(C_FULL, U_ERRF, IDX_LOAD_LEN, RD_NONE, WR_NONE, LEN_HOLD,
                        EMIT_NONE, ST_ELEMENT, 1'b0);
         U_ADD2: w = uw(C_IDX_AT_POS, U_ADD4, IDX_HOLD, RD_IDX_M1, WR_NONE, LEN_HOLD,
                        EMIT_NONE, ST_ELEMENT, 1'b0);
         U_ADD3: w = uw(C_ALWAYS, U_ADD2, IDX_DEC, RD_NONE, WR_RDATA_IDX, LEN_HOLD,
                        EMIT_NONE, ST_ELEMENT, 1'b0);
         U_ADD4: w = uw(C_NEVER, U_ADD0, IDX_HOLD, RD_NONE, WR_BYTE_IDX, LEN_INC,
                        EMIT_NONE, ST_ELEMENT, 1'b1);
         U_DEL0: w = uw(C_BAD_POS, U_ERRP, IDX_LOAD_POS, RD_NONE, WR_NONE, LEN_HOLD,
                        EMIT_NONE, ST_ELEMENT, 1'b0);
         U_DEL1: w = uw(C_IDX_AT_LEN, U_DEL3, IDX_HOLD, RD_IDX, WR_NONE, LEN_HOLD,
                        EMIT_NONE, ST_ELEMENT, 1'b0);
         U_DEL2: w = uw(C_ALWAYS, U_DEL1, IDX_INC, RD_NONE, WR_RDATA_IDX_M1, LEN_HOLD,
                        EMIT_NONE, ST_ELEMENT, 1'b0);
         U_DEL3: w = uw(C_NEVER, U_ADD0, IDX_HOLD, RD_NONE, WR_NONE, LEN_DEC,
                        EMIT_NONE, ST_ELEMENT, 1'b1);
         U_GET0: w = uw(C_BAD_POS, U_ERRP, IDX_HOLD, RD_POS_M1, WR_NONE, LEN_HOLD,
                        EMIT_NONE, ST_ELEMENT, 1'b0);
         U_GET1: w = uw(C_NEVER, U_ADD0, IDX_HOLD, RD_NONE, WR_NONE, LEN_HOLD,
                        EMIT_ELEM_ONE, ST_ELEMENT, 1'b1);
         U_PRT0: w = uw(C_EMPTY, U_ERRE, IDX_ZERO, RD_NONE, WR_NONE, LEN_HOLD,
                        EMIT_NONE, ST_ELEMENT, 1'b0);
         U_PRT1: w = uw(C_NEVER, U_ADD0, IDX_INC, RD_IDX, WR_NONE, LEN_HOLD,
                        EMIT_NONE, ST_ELEMENT, 1'b0);
         U_PRT2: w = uw(C_IDX_BELOW_LEN, U_PRT1, IDX_HOLD, RD_NONE, WR_NONE, LEN_HOLD,
                        EMIT_ELEM_RUN, ST_ELEMENT, 1'b1);
         U_ERRP: w = uw(C_NEVER, U_ADD0, IDX_HOLD, RD_NONE, WR_NONE, LEN_HOLD,
                        EMIT_ERR, ST_BAD_POS, 1'b1);
         U_ERRF: w = uw(C_NEVER, U_ADD0, IDX_HOLD, RD_NONE, WR_NONE, LEN_HOLD,
                        EMIT_ERR, ST_FULL, 1'b1);
         U_ERRE: w = uw(C_NEVER, U_ADD0, IDX_HOLD, RD_NONE, WR_NONE, LEN_HOLD,
                        EMIT_ERR, ST_EMPTY, 1'b1);
         default: w = uword_nop();
      endcase
      return w;
   endfunction

   function automatic upc_type entry_point(input action_type act);
      upc_type e;
      e = U_ADD0;
      unique case (act)
         ACT_ADD:    e = U_ADD0;
         ACT_DELETE: e = U_DEL0;
         ACT_GET:    e = U_GET0;
         ACT_PRINT:  e = U_PRT0;
         default:    e = U_ADD0;
      endcase
      return e;
   endfunction

endpackage

### rtl/positional_list_engine_core.sv
// Positional list engine: ranked insert, delete, get and print over a byte store.
// Depends on plm_pkg, plm_ram and plm_sequencer.
// Each element moved or printed takes two microcode steps; the store has one write and one read port.
// Each result beat is registered and appears in the cycle after the step that forms it; the receiver cannot stall.
// Reset clears the length, result valid flag and sequencer; element store contents stay undefined until written.
module positional_list_engine_core #(
   parameter int CAPACITY = plm_pkg::CAPACITY_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [plm_pkg::ACTION_W-1:0]  req_action,
   input  logic [plm_pkg::POS_W-1:0]     req_position,
   input  logic [plm_pkg::CHAR_W-1:0]    req_new_char,
   output logic                          rsp_valid,
   output logic [plm_pkg::STATUS_W-1:0]  rsp_status,
   output logic [plm_pkg::CHAR_W-1:0]    rsp_out_char,
   output logic                          rsp_last
);
   import plm_pkg::*;

   localparam int AW    = $clog2(CAPACITY);
   localparam int LEN_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = ((LEN_W > POS_W) ? LEN_W : POS_W) + 1;

   uword_type   ctl;
   flags_type   flags;
   logic        accept;

   action_type         action_ff;
   logic [POS_W-1:0]   pos_ff;
   logic [CHAR_W-1:0]  byte_ff;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [LEN_W-1:0]   idx_ff, idx_in;
   logic [LEN_W-1:0]   idx_m1;
   logic [POS_W-1:0]   pos_m1;
   logic [CMP_W-1:0]   pos_c, len_c, idx_c;

   logic               ram_wr_en, ram_rd_en;
   logic [AW-1:0]      ram_wr_addr, ram_rd_addr;
   logic [CHAR_W-1:0]  ram_wr_data, ram_rd_data;

   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [CHAR_W-1:0]  rsp_char_ff, rsp_char_in;
   logic               rsp_last_ff, rsp_last_in;

   assign accept = start && !busy;

   plm_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .action (req_action),
      .flags  (flags),
      .busy   (busy),
      .ctl    (ctl)
   );

   plm_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      pos_c  = CMP_W'(pos_ff);
      len_c  = CMP_W'(len_ff);
      idx_c  = CMP_W'(idx_ff);
      idx_m1 = idx_ff - LEN_W'(1);
      pos_m1 = pos_ff - POS_W'(1);

      flags.bad_pos = (pos_ff == '0) ||
                      ((action_ff == ACT_ADD) ? (pos_c > len_c + CMP_W'(1))
                                              : (pos_c > len_c));
      flags.full          = (len_ff == LEN_W'(CAPACITY));
      flags.empty         = (len_ff == '0);
      flags.idx_at_pos    = (idx_c + CMP_W'(1) == pos_c);
      flags.idx_at_len    = (idx_ff == len_ff);
      flags.idx_below_len = (idx_ff < len_ff);

      ram_rd_en   = 1'b1;
      ram_rd_addr = idx_ff[AW-1:0];
      case (ctl.rd_sel)
         RD_NONE:   ram_rd_en   = 1'b0;
         RD_IDX:    ram_rd_addr = idx_ff[AW-1:0];
         RD_IDX_M1: ram_rd_addr = idx_m1[AW-1:0];
         RD_POS_M1: ram_rd_addr = pos_m1[AW-1:0];
         default:   ram_rd_en   = 1'b0;
      endcase

      ram_wr_en   = 1'b1;
      ram_wr_addr = idx_ff[AW-1:0];
      ram_wr_data = ram_rd_data;
      case (ctl.wr_sel)
         WR_NONE:         ram_wr_en   = 1'b0;
         WR_RDATA_IDX:    ram_wr_addr = idx_ff[AW-1:0];
         WR_RDATA_IDX_M1: ram_wr_addr = idx_m1[AW-1:0];
         WR_BYTE_IDX:     ram_wr_data = byte_ff;
         default:         ram_wr_en   = 1'b0;
      endcase

      idx_in = idx_ff;
      case (ctl.idx_op)
         IDX_LOAD_LEN: idx_in = len_ff;
         IDX_LOAD_POS: idx_in = LEN_W'(pos_ff);
         IDX_ZERO:     idx_in = '0;
         IDX_INC:      idx_in = idx_ff + LEN_W'(1);
         IDX_DEC:      idx_in = idx_m1;
         default:      idx_in = idx_ff;
      endcase

      len_in = len_ff;
      case (ctl.len_op)
         LEN_INC: len_in = len_ff + LEN_W'(1);
         LEN_DEC: len_in = len_ff - LEN_W'(1);
         default: len_in = len_ff;
      endcase

      rsp_valid_in  = (ctl.emit != EMIT_NONE);
      rsp_status_in = ST_ELEMENT;
      rsp_char_in   = ram_rd_data;
      rsp_last_in   = 1'b1;
      case (ctl.emit)
         EMIT_ELEM_RUN: rsp_last_in = (idx_ff == len_ff);
         EMIT_ERR: begin
            rsp_status_in = ctl.status;
            rsp_char_in   = '0;
         end
         default: rsp_last_in = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff <= req_action;
         pos_ff    <= req_position;
         byte_ff   <= req_new_char;
      end
      idx_ff        <= idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_char_ff   <= rsp_char_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_out_char = rsp_char_ff;
   assign rsp_last     = rsp_last_ff;

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_W'(CAPACITY))
      else $error("list length beyond capacity");

   a_no_idle_write: assert property (@(posedge clock) disable iff (reset)
      !busy |-> !ram_wr_en)
      else $error("store written while idle");

   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result beat without a running item");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted item did not raise busy");

endmodule

### rtl/plm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module plm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/plm_sequencer.sv
// Microcode sequencer: step counter, busy flag and control word lookup.
// Depends on plm_pkg.
module plm_sequencer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  plm_pkg::action_type  action,
   input  plm_pkg::flags_type   flags,
   output logic                 busy,
   output plm_pkg::uword_type   ctl
);
   import plm_pkg::*;

   logic      busy_ff, busy_in;
   upc_type   pc_ff, pc_in;
   uword_type word;
   logic      cond_true;

   always_comb begin
      word = ucode_rom(pc_ff);
      cond_true = 1'b0;
      unique case (word.cond)
         C_NEVER:         cond_true = 1'b0;
         C_ALWAYS:        cond_true = 1'b1;
         C_BAD_POS:       cond_true = flags.bad_pos;
         C_FULL:          cond_true = flags.full;
         C_EMPTY:         cond_true = flags.empty;
         C_IDX_AT_POS:    cond_true = flags.idx_at_pos;
         C_IDX_AT_LEN:    cond_true = flags.idx_at_len;
         C_IDX_BELOW_LEN: cond_true = flags.idx_below_len;
         default:         cond_true = 1'b0;
      endcase

      busy_in = busy_ff;
      pc_in   = pc_ff;
      if (!busy_ff) begin
         if (start) begin
            busy_in = 1'b1;
            pc_in   = entry_point(action);
         end
      end else if (cond_true) begin
         pc_in = word.target;
      end else if (word.done) begin
         busy_in = 1'b0;
      end else begin
         pc_in = pc_ff + UPC_W'(1);
      end

      ctl = busy_ff ? word : uword_nop();
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pc_ff   <= U_ADD0;
      end else begin
         busy_ff <= busy_in;
         pc_ff   <= pc_in;
      end
   end

   assign busy = busy_ff;

endmodule

### test/positional_list_engine_core_test.sv
// Self-checking testbench for positional_list_engine_core: ranked add, delete, get and print.
// Depends on plm_pkg and the RTL in rtl/; keeps its own list of bytes to predict each beat.
module positional_list_engine_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import plm_pkg::*;

   localparam int LIST_CAP = CAPACITY_DEFAULT;

   typedef struct packed {
      status_type        status;
      logic [CHAR_W-1:0] value;
      logic              last;
   } list_beat_type;

   typedef enum int { MODE_GROW, MODE_SHRINK, MODE_MIXED } churn_mode_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   action_type          req_action = ACT_ADD;
   logic [POS_W-1:0]    req_position = '0;
   logic [CHAR_W-1:0]   req_new_char = '0;
   logic                rsp_valid;
   status_type          rsp_status;
   logic [CHAR_W-1:0]   rsp_out_char;
   logic                rsp_last;

   logic [CHAR_W-1:0]   list_contents[$];
   list_beat_type       due_beats[$];
   list_beat_type       want_beat;
   int                  fail_count = 0;
   int                  idle_pct = 0;

   positional_list_engine_core dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_action   (req_action),
      .req_position (req_position),
      .req_new_char (req_new_char),
      .rsp_valid    (rsp_valid),
      .rsp_status   (rsp_status),
      .rsp_out_char (rsp_out_char),
      .rsp_last     (rsp_last)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("positional_list_engine_core: mismatch");
      $finish;
   end

   function automatic void push_beat(status_type st, logic [CHAR_W-1:0] v, logic l);
      list_beat_type b;
      b.status = st;
      b.value  = v;
      b.last   = l;
      due_beats.push_back(b);
   endfunction

   function automatic void predict_list_action(action_type act, logic [POS_W-1:0] pos,
                                               logic [CHAR_W-1:0] nc);
      int len;
      int p;
      len = list_contents.size();
      p = pos;
      case (act)
         ACT_ADD: begin
            if (p < 1 || p > len + 1) push_beat(ST_BAD_POS, '0, 1'b1);
            else if (len >= LIST_CAP) push_beat(ST_FULL, '0, 1'b1);
            else list_contents.insert(p - 1, nc);
         end
         ACT_DELETE: begin
            if (p < 1 || p > len) push_beat(ST_BAD_POS, '0, 1'b1);
            else list_contents.delete(p - 1);
         end
         ACT_GET: begin
            if (p < 1 || p > len) push_beat(ST_BAD_POS, '0, 1'b1);
            else push_beat(ST_ELEMENT, list_contents[p - 1], 1'b1);
         end
         default: begin
            if (len == 0) push_beat(ST_EMPTY, '0, 1'b1);
            else for (int i = 0; i < len; i++)
               push_beat(ST_ELEMENT, list_contents[i], i == len - 1);
         end
      endcase
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (due_beats.size() == 0) begin
            $error("unexpected beat: status %0d out_char %0h last %0b",
                   rsp_status, rsp_out_char, rsp_last);
            fail_count++;
         end else begin
            want_beat = due_beats.pop_front();
            if (rsp_status !== want_beat.status) begin
               $error("status: expected %0d, got %0d", want_beat.status, rsp_status);
               fail_count++;
            end
            if (rsp_out_char !== want_beat.value) begin
               $error("out_char: expected %0h, got %0h", want_beat.value, rsp_out_char);
               fail_count++;
            end
            if (rsp_last !== want_beat.last) begin
               $error("last: expected %0b, got %0b", want_beat.last, rsp_last);
               fail_count++;
            end
         end
      end
   end

   task automatic idle_for(input int n);
      @(negedge clock);
      start <= 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   task automatic send_item(input action_type act, input logic [POS_W-1:0] pos,
                            input logic [CHAR_W-1:0] nc);
      while ($urandom_range(99) < idle_pct) idle_for(1);
      @(negedge clock);
      start        <= 1'b1;
      req_action   <= act;
      req_position <= pos;
      req_new_char <= nc;
      do @(posedge clock); while (busy);
      predict_list_action(act, pos, nc);
   endtask

   // hold off the sender until every predicted beat has arrived
   task automatic wait_drained();
      @(negedge clock);
      start <= 1'b0;
      while (due_beats.size() != 0) @(posedge clock);
   endtask

   task automatic test_empty_list();
      send_item(ACT_PRINT, 6'd0, 8'h00);
      send_item(ACT_GET, 6'd0, 8'hFF);
      send_item(ACT_GET, 6'd1, 8'h00);
      send_item(ACT_DELETE, 6'd0, 8'h00);
      send_item(ACT_DELETE, 6'd1, 8'hFF);
      send_item(ACT_ADD, 6'd0, 8'h11);
      send_item(ACT_ADD, 6'd2, 8'h22);
      send_item(ACT_ADD, 6'd63, 8'hFF);
   endtask

   task automatic test_edge_ranks();
      send_item(ACT_ADD, 6'd1, 8'h00);
      send_item(ACT_ADD, 6'd2, 8'hFF);
      send_item(ACT_ADD, 6'd1, 8'hA5);
      send_item(ACT_ADD, 6'd2, 8'h5A);
      send_item(ACT_ADD, 6'd6, 8'h33);
      send_item(ACT_PRINT, 6'd63, 8'hFF);
      send_item(ACT_GET, 6'd1, 8'h00);
      send_item(ACT_GET, 6'd4, 8'h00);
      send_item(ACT_GET, 6'd5, 8'h00);
      send_item(ACT_DELETE, 6'd5, 8'h00);
      send_item(ACT_DELETE, 6'd4, 8'h00);
      send_item(ACT_DELETE, 6'd1, 8'h00);
      send_item(ACT_GET, 6'd63, 8'h00);
      send_item(ACT_DELETE, 6'd1, 8'h00);
      send_item(ACT_DELETE, 6'd1, 8'h00);
      send_item(ACT_PRINT, 6'd0, 8'h00);
   endtask

   // rank is checked before fullness, so an add one beyond len+1 still reports a bad rank
   task automatic test_list_full();
      while (list_contents.size() < LIST_CAP)
         send_item(ACT_ADD, POS_W'($urandom_range(1, list_contents.size() + 1)),
                   CHAR_W'($urandom));
      send_item(ACT_ADD, 6'd1, CHAR_W'($urandom));
      send_item(ACT_ADD, POS_W'(LIST_CAP + 1), CHAR_W'($urandom));
      send_item(ACT_ADD, POS_W'(LIST_CAP + 2), CHAR_W'($urandom));
      send_item(ACT_ADD, 6'd0, CHAR_W'($urandom));
      send_item(ACT_PRINT, 6'd0, 8'h00);
      send_item(ACT_GET, POS_W'(LIST_CAP), 8'h00);
      send_item(ACT_DELETE, POS_W'(LIST_CAP + 1), 8'h00);
      while (list_contents.size() > 0)
         send_item(ACT_DELETE, POS_W'($urandom_range(1, list_contents.size())),
                   CHAR_W'($urandom));
      send_item(ACT_PRINT, 6'd0, 8'h00);
   endtask

   task automatic test_random_churn(input int count);
      churn_mode_type mode;
      action_type     act;
      int             len;
      int             r;
      int             top;
      logic [POS_W-1:0] pos;
      mode = MODE_GROW;
      repeat (count) begin
         len = list_contents.size();
         if (len == LIST_CAP && $urandom_range(99) < 30) mode = MODE_SHRINK;
         else if (len == 0) mode = MODE_GROW;
         else if ($urandom_range(99) < 4) mode = MODE_MIXED;
         r = $urandom_range(99);
         case (mode)
            MODE_GROW:   act = r < 60 ? ACT_ADD : r < 70 ? ACT_DELETE : r < 88 ? ACT_GET
                                                                     : ACT_PRINT;
            MODE_SHRINK: act = r < 10 ? ACT_ADD : r < 65 ? ACT_DELETE : r < 88 ? ACT_GET
                                                                     : ACT_PRINT;
            default:     act = r < 30 ? ACT_ADD : r < 60 ? ACT_DELETE : r < 88 ? ACT_GET
                                                                     : ACT_PRINT;
         endcase
         top = (act == ACT_ADD) ? len + 1 : len;
         r = $urandom_range(99);
         if (top > 0 && r < 85) pos = POS_W'($urandom_range(1, top));
         else if (r < 90) pos = '0;
         else if (r < 95) pos = POS_W'(top + 1);
         else pos = POS_W'($urandom);
         send_item(act, pos, CHAR_W'($urandom));
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      idle_pct = 18;
      test_empty_list();
      test_edge_ranks();
      wait_drained();
      test_list_full();
      test_random_churn(140);

      idle_pct = 83;
      wait_drained();
      test_random_churn(140);

      idle_pct = 0;
      test_random_churn(140);

      wait_drained();
      repeat (80) @(posedge clock);
      if (fail_count == 0) $display("positional_list_engine_core: match");
      else $display("positional_list_engine_core: mismatch");
      $finish;
   end

endmodule
